// ===== rtl/bitmap_contiguous_run_allocator_macros.svh =====
// assertion macros shared by the allocator checker
// needs a clock and an active-high reset named by the caller
`ifndef BITMAP_CONTIGUOUS_RUN_ALLOCATOR_MACROS_SVH
`define BITMAP_CONTIGUOUS_RUN_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define BCRA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// next-cycle implication, disabled during reset
`define BCRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

// ===== rtl/bcra_pkg.sv =====
// shared types and constants of the contiguous run allocator
// no dependencies
`default_nettype none

package bcra_pkg;

   // field widths of the item, result and register port
   localparam int ENTRY_INDEX_W = 10;
   localparam int RUN_LENGTH_W  = 11;
   localparam int START_W       = 10;
   localparam int POLICY_W      = 2;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 11;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FIT_POLICY     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRIES_IN_USE = 1'b1;

   // register reset values
   localparam logic [POLICY_W-1:0]     POLICY_RESET  = 2'd0;
   localparam logic [RUN_LENGTH_W-1:0] ENTRIES_RESET = 11'd1024;

   // fit policy codes, the two upper codes both mean worst fit
   localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;

   // item mode codes
   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   // controller states
   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/bcra_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module bcra_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/bitmap_contiguous_run_allocator.sv =====
// Contiguous free-run allocator over a used/free bitmap held in one ram.
// After reset the map is cleared one entry a cycle, and req_ready stays low
// until that clearing pass is done; register writes are taken at any time. A write
// item changes one map bit and its result (found 0, start 0) goes through the done
// state into the output register; no new item is accepted until that result has
// been loaded there. A search item scans entries 0 to n-1 (n = entries_in_use,
// capped at MAP_ENTRIES), one entry a cycle from the ram's read port, plus one
// closing step, and its result goes through the done state in the same manner.
// A finished result sits in an output register, and the next item is accepted
// while it waits to be taken.
`default_nettype none

module bitmap_contiguous_run_allocator #(
   parameter int MAP_ENTRIES = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic [bcra_pkg::ENTRY_INDEX_W-1:0] req_entry_index,
   input  logic                               req_entry_used,
   input  logic [bcra_pkg::RUN_LENGTH_W-1:0]  req_run_length,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_found,
   output logic [bcra_pkg::START_W-1:0]       rsp_start_index,
   input  logic                               csr_write_enable,
   input  logic [bcra_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bcra_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   import bcra_pkg::*;

   localparam int AW = $clog2(MAP_ENTRIES);
   localparam int CW = $clog2(MAP_ENTRIES + 1);
   localparam logic [AW-1:0] MAP_LAST = AW'(MAP_ENTRIES - 1);

   state_type state_ff, state_in;

   logic [AW-1:0]           clr_ptr_ff, clr_ptr_in;
   logic [POLICY_W-1:0]     fit_policy_ff, fit_policy_in;
   logic [RUN_LENGTH_W-1:0] entries_in_use_ff, entries_in_use_in;

   logic [RUN_LENGTH_W-1:0] need_ff, need_in;
   logic [CW-1:0]           scan_n_ff, scan_n_in;
   logic [CW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic                    iss_done_ff, iss_done_in;
   logic                    p_vld_ff, p_vld_in;
   logic                    p_end_ff, p_end_in;
   logic [AW-1:0]           p_idx_ff, p_idx_in;

   logic [AW-1:0] run_start_ff, run_start_in;
   logic [CW-1:0] run_len_ff, run_len_in;
   logic [AW-1:0] chosen_start_ff, chosen_start_in;
   logic [CW-1:0] chosen_len_ff, chosen_len_in;
   logic          have_ff, have_in;

   logic          res_found_ff, res_found_in;
   logic [AW-1:0] res_start_ff, res_start_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [START_W-1:0] rsp_start_ff, rsp_start_in;

   logic          req_take;
   logic          rsp_load;
   logic [31:0]   idx_wide;
   logic [31:0]   eiu_wide;
   logic          idx_in_map;
   logic          issue;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic          ram_wr_data;
   logic          ram_rd_en;
   logic          ram_rd_data;
   logic          is_free;
   logic          len_ok;
   logic          better;
   logic          take;
   logic [31:0]   start_wide;

   // map storage
   bcra_ram #(
      .WIDTH (1),
      .DEPTH (MAP_ENTRIES)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // write address and range check
   assign idx_wide   = 32'(req_entry_index);
   assign idx_in_map = (idx_wide < 32'(MAP_ENTRIES));
   assign eiu_wide   = 32'(entries_in_use_ff);

   // ram write port: clearing pass or item write
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ptr_ff;
         ram_wr_data = 1'b0;
      end else begin
         ram_wr_en   = req_take && (req_mode == MODE_WRITE) && idx_in_map;
         ram_wr_addr = idx_wide[AW-1:0];
         ram_wr_data = req_entry_used;
      end
   end

   // scan issue stage, the last step past the scan end reads nothing
   assign issue     = (state_ff == ST_SCAN) && !iss_done_ff;
   assign ram_rd_en = issue && (rd_ptr_ff != scan_n_ff);

   // run tracking step on the entry returned by the ram
   assign is_free = p_vld_ff && !p_end_ff && !ram_rd_data;
   assign len_ok  = (32'(run_len_ff) >= 32'(need_ff));
   assign better  = (fit_policy_ff == POLICY_BEST) ? (run_len_ff < chosen_len_ff)
                                                   : (run_len_ff > chosen_len_ff);
   assign take    = p_vld_ff && !is_free && (run_len_ff != '0) && len_ok &&
                    (!have_ff || ((fit_policy_ff != POLICY_FIRST) && better));

   // configuration registers
   always_comb begin
      fit_policy_in     = fit_policy_ff;
      entries_in_use_in = entries_in_use_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FIT_POLICY:     fit_policy_in     = csr_write_data[POLICY_W-1:0];
            CSR_ENTRIES_IN_USE: entries_in_use_in = csr_write_data[RUN_LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   // controller
   always_comb begin
      state_in        = state_ff;
      clr_ptr_in      = clr_ptr_ff;
      need_in         = need_ff;
      scan_n_in       = scan_n_ff;
      rd_ptr_in       = rd_ptr_ff;
      iss_done_in     = iss_done_ff;
      p_vld_in        = issue;
      p_end_in        = (rd_ptr_ff == scan_n_ff);
      p_idx_in        = rd_ptr_ff[AW-1:0];
      run_start_in    = run_start_ff;
      run_len_in      = run_len_ff;
      chosen_start_in = chosen_start_ff;
      chosen_len_in   = chosen_len_ff;
      have_in         = have_ff;
      res_found_in    = res_found_ff;
      res_start_in    = res_start_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_ptr_in = clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == MAP_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               if (req_mode == MODE_WRITE) begin
                  res_found_in = 1'b0;
                  res_start_in = '0;
                  state_in     = ST_DONE;
               end else begin
                  need_in   = (req_run_length == '0) ? RUN_LENGTH_W'(1) : req_run_length;
                  scan_n_in = (eiu_wide > 32'(MAP_ENTRIES)) ? CW'(MAP_ENTRIES)
                                                            : CW'(eiu_wide);
                  rd_ptr_in       = '0;
                  iss_done_in     = 1'b0;
                  run_start_in    = '0;
                  run_len_in      = '0;
                  chosen_start_in = '0;
                  chosen_len_in   = '0;
                  have_in         = 1'b0;
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // advance the read pointer up to the closing step
            if (issue) begin
               if (rd_ptr_ff == scan_n_ff) begin
                  iss_done_in = 1'b1;
               end else begin
                  rd_ptr_in = rd_ptr_ff + 1'b1;
               end
            end
            // fold the returned entry into the current run
            if (p_vld_ff) begin
               if (is_free) begin
                  if (run_len_ff == '0) begin
                     run_start_in = p_idx_ff;
                  end
                  run_len_in = run_len_ff + 1'b1;
               end else begin
                  if (take) begin
                     chosen_start_in = run_start_ff;
                     chosen_len_in   = run_len_ff;
                     have_in         = 1'b1;
                  end
                  run_len_in = '0;
               end
               if (p_end_ff) begin
                  res_found_in = have_ff || take;
                  res_start_in = take ? run_start_ff : (have_ff ? chosen_start_ff : '0);
                  state_in     = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register
   assign start_wide = 32'(res_start_ff);
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = res_found_ff;
         rsp_start_in = start_wide[START_W-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_CLEAR;
         clr_ptr_ff        <= '0;
         fit_policy_ff     <= POLICY_RESET;
         entries_in_use_ff <= ENTRIES_RESET;
         iss_done_ff       <= 1'b0;
         p_vld_ff          <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         clr_ptr_ff        <= clr_ptr_in;
         fit_policy_ff     <= fit_policy_in;
         entries_in_use_ff <= entries_in_use_in;
         iss_done_ff       <= iss_done_in;
         p_vld_ff          <= p_vld_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      need_ff         <= need_in;
      scan_n_ff       <= scan_n_in;
      rd_ptr_ff       <= rd_ptr_in;
      p_end_ff        <= p_end_in;
      p_idx_ff        <= p_idx_in;
      run_start_ff    <= run_start_in;
      run_len_ff      <= run_len_in;
      chosen_start_ff <= chosen_start_in;
      chosen_len_ff   <= chosen_len_in;
      have_ff         <= have_in;
      res_found_ff    <= res_found_in;
      res_start_ff    <= res_start_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_start_ff    <= rsp_start_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_start_index = rsp_start_ff;

endmodule

`default_nettype wire

// ===== rtl/bcra_checker.sv =====
// port-level checks of the contiguous run allocator, bound to the top level
// depends on bcra_pkg and the allocator macro header
`default_nettype none

`include "bitmap_contiguous_run_allocator_macros.svh"

module bcra_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic                         rsp_found,
   input wire logic [bcra_pkg::START_W-1:0] rsp_start_index
);

   import bcra_pkg::*;

   logic [2:0]     open_ff, open_in;
   logic           req_take;
   logic           rsp_take;
   logic           rsp_stall;
   logic [START_W:0] rsp_payload;

   assign req_take    = req_valid && req_ready;
   assign rsp_take    = rsp_valid && rsp_ready;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_found, rsp_start_index};

   // items accepted whose results are not yet taken
   always_comb begin
      open_in = open_ff;
      if (req_take && !rsp_take) begin
         open_in = open_ff + 1'b1;
      end else if (!req_take && rsp_take) begin
         open_in = open_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // a stalled result stays offered with the same payload
   `BCRA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid)
   `BCRA_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_payload))

   // a missing run reports a zero start
   `BCRA_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_found, rsp_start_index == '0)

   // one item in work and one result waiting at most, and no result from nothing
   `BCRA_ASSERT_NOW(a_open_bound, clock, reset, 1'b1, open_ff <= 3'd2 && (!rsp_valid || open_ff != '0))

endmodule

bind bitmap_contiguous_run_allocator bcra_checker u_bcra_checker (.*);

`default_nettype wire

// ===== tb/tb_bitmap_contiguous_run_allocator.sv =====
// testbench for the contiguous free-run allocator: directed rows, then random phases
// checks every result against the row's typed expectation or a local model of the used/free map and the fit policies
// depends on bcra_pkg and bitmap_contiguous_run_allocator
`default_nettype none

module tb_bitmap_contiguous_run_allocator;
   import bcra_pkg::*;

   localparam int MAP_SIZE      = 1024;
   localparam int RANDOM_ITEMS  = 580;
   localparam int LIMIT_CYCLES  = 3_000_000;
   localparam int SETTLE_CYCLES = 8;

   // policy codes with no package name; both mean worst fit
   localparam logic [POLICY_W-1:0] POLICY_WORST     = 2'd2;
   localparam logic [POLICY_W-1:0] POLICY_WORST_ALT = 2'd3;

   typedef struct packed {
      logic                found;
      logic [START_W-1:0]  start;
   } outcome_type;

   typedef enum logic [1:0] {ROW_WRITE, ROW_SEARCH, ROW_POLICY, ROW_ENTRIES} row_kind_type;

   // arg is the entry index, run length or register value depending on kind
   typedef struct packed {
      row_kind_type        kind;
      logic [10:0]         arg;
      logic                used;
      logic                typed;
      logic                found;
      logic [START_W-1:0]  start;
   } row_type;

   localparam row_type PLAN [0:32] = '{
      '{ROW_SEARCH,  11'd1,    1'b0, 1'b1, 1'b1, 10'd0},
      '{ROW_SEARCH,  11'd1024, 1'b0, 1'b1, 1'b1, 10'd0},
      '{ROW_SEARCH,  11'd1025, 1'b0, 1'b1, 1'b0, 10'd0},
      '{ROW_SEARCH,  11'd0,    1'b0, 1'b1, 1'b1, 10'd0},
      '{ROW_WRITE,   11'd0,    1'b1, 1'b1, 1'b0, 10'd0},
      '{ROW_WRITE,   11'd1023, 1'b1, 1'b1, 1'b0, 10'd0},
      '{ROW_SEARCH,  11'd1022, 1'b0, 1'b1, 1'b1, 10'd1},
      '{ROW_SEARCH,  11'd2047, 1'b0, 1'b1, 1'b0, 10'd0},
      '{ROW_WRITE,   11'd5,    1'b1, 1'b1, 1'b0, 10'd0},
      '{ROW_POLICY,  11'(POLICY_BEST),      1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH,  11'd2,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_POLICY,  11'(POLICY_WORST),     1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH,  11'd2,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_POLICY,  11'(POLICY_WORST_ALT), 1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH,  11'd1,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_ENTRIES, 11'd0,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH,  11'd1,    1'b0, 1'b1, 1'b0, 10'd0},
      '{ROW_ENTRIES, 11'd2047, 1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH,  11'd1,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_ENTRIES, 11'd1,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH,  11'd1,    1'b0, 1'b1, 1'b0, 10'd0},
      '{ROW_WRITE,   11'd0,    1'b0, 1'b1, 1'b0, 10'd0},
      '{ROW_SEARCH,  11'd1,    1'b0, 1'b1, 1'b1, 10'd0},
      '{ROW_ENTRIES, 11'd12,   1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_POLICY,  11'(POLICY_BEST),      1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_WRITE,   11'd2,    1'b1, 1'b1, 1'b0, 10'd0},
      '{ROW_SEARCH,  11'd2,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH,  11'd3,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_POLICY,  11'(POLICY_FIRST),     1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH,  11'd3,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH,  11'd6,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH,  11'd7,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_WRITE,   11'd1023, 1'b0, 1'b1, 1'b0, 10'd0}
   };

   logic                      clock;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_ready;
   logic                      req_mode         = MODE_WRITE;
   logic [ENTRY_INDEX_W-1:0]  req_entry_index  = '0;
   logic                      req_entry_used   = 1'b0;
   logic [RUN_LENGTH_W-1:0]   req_run_length   = '0;
   logic                      rsp_valid;
   logic                      rsp_ready        = 1'b0;
   logic                      rsp_found;
   logic [START_W-1:0]        rsp_start_index;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index        = CSR_FIT_POLICY;
   logic [CSR_DATA_W-1:0]     csr_write_data   = '0;

   // local copy of the map and registers
   bit [MAP_SIZE-1:0]         used_map     = '0;
   logic [POLICY_W-1:0]       fit_code     = POLICY_RESET;
   logic [RUN_LENGTH_W-1:0]   scan_entries = ENTRIES_RESET;

   outcome_type               pending_q [$];
   outcome_type               got_item;
   outcome_type               want_item;

   int  error_count      = 0;
   int  items_accepted   = 0;
   int  searches_sent    = 0;
   int  runs_found       = 0;
   int  settings_written = 0;
   int  cycle_count      = 0;
   int  rsp_wait         = 0;
   bit  req_idle_on      = 1'b1;
   bit  rsp_stall_on     = 1'b1;

   bitmap_contiguous_run_allocator #(.MAP_ENTRIES(MAP_SIZE)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_entry_index  (req_entry_index),
      .req_entry_used   (req_entry_used),
      .req_run_length   (req_run_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_start_index  (rsp_start_index),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // split the scanned entries into free runs and pick one under the policy
   function automatic outcome_type find_free_run(input logic [RUN_LENGTH_W-1:0] want);
      int          n, need, i, run_begin, run_len, pick_begin, pick_len;
      bit          taken, stop, here_free, better;
      outcome_type res;
      n = (scan_entries > MAP_SIZE) ? MAP_SIZE : int'(scan_entries);
      need = (want == 0) ? 1 : int'(want);
      run_begin = 0;
      run_len = 0;
      pick_begin = 0;
      pick_len = 0;
      taken = 1'b0;
      stop = 1'b0;
      for (i = 0; i <= n && !stop; i++) begin
         here_free = (i < n) && !used_map[i];
         if (here_free) begin
            if (run_len == 0) run_begin = i;
            run_len++;
         end else begin
            if (run_len >= need) begin
               if (!taken) better = 1'b1;
               else if (fit_code == POLICY_BEST) better = run_len < pick_len;
               else better = run_len > pick_len;
               if (better) begin
                  pick_begin = run_begin;
                  pick_len = run_len;
                  taken = 1'b1;
                  if (fit_code == POLICY_FIRST) stop = 1'b1;
               end
            end
            run_len = 0;
         end
      end
      res.found = taken;
      res.start = taken ? pick_begin[START_W-1:0] : '0;
      return res;
   endfunction

   // offer one item after a random gap and log its expected result once accepted
   task automatic send_item(input logic mode, input logic [ENTRY_INDEX_W-1:0] idx,
                            input logic used, input logic [RUN_LENGTH_W-1:0] len,
                            input bit typed, input outcome_type typed_out);
      int          gap;
      outcome_type predicted;
      if ($urandom_range(0, 31) == 0) req_idle_on = !req_idle_on;
      gap = req_idle_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_entry_index <= idx;
      req_entry_used  <= used;
      req_run_length  <= len;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (mode == MODE_WRITE) begin
         used_map[idx] = used;
         predicted = '0;
      end else begin
         predicted = find_free_run(len);
         searches_sent++;
      end
      pending_q.push_back(typed ? typed_out : predicted);
      items_accepted++;
   endtask

   // register write once every expected result has come back
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_FIT_POLICY) fit_code = data[POLICY_W-1:0];
      else scan_entries = data;
      settings_written++;
   endtask

   // result side: random stall per item, compare against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got_item.found = rsp_found;
         got_item.start = rsp_start_index;
         if (pending_q.size() == 0) begin
            $display("%0t: result with nothing expected, found %0b start %0d",
                     $time, got_item.found, got_item.start);
            error_count++;
         end else begin
            want_item = pending_q.pop_front();
            if (got_item.found !== want_item.found) begin
               $display("%0t: found expected %0b actual %0b",
                        $time, want_item.found, got_item.found);
               error_count++;
            end
            if (got_item.start !== want_item.start) begin
               $display("%0t: start_index expected %0d actual %0d",
                        $time, want_item.start, got_item.start);
               error_count++;
            end
         end
         if (got_item.found === 1'b1) runs_found++;
         if ($urandom_range(0, 31) == 0) rsp_stall_on = !rsp_stall_on;
         rsp_wait = rsp_stall_on ? $urandom_range(0, 6) : 0;
      end else if (rsp_valid === 1'b1 && rsp_wait != 0) begin
         rsp_wait--;
      end
      rsp_ready <= (rsp_wait == 0);
   end

   // watchdog
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[bitmap_contiguous_run_allocator] ERROR");
      $finish;
   end

   initial begin
      int          r, phase, count, k, span, density, roll, random_sent;
      logic [CSR_DATA_W-1:0] entries;
      logic        mode, used;
      logic [ENTRY_INDEX_W-1:0] idx;
      logic [RUN_LENGTH_W-1:0]  len;
      outcome_type row_out;
      random_sent = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed rows: extremes, every policy, scan length corners
      for (r = 0; r < 33; r++) begin
         row_out.found = PLAN[r].found;
         row_out.start = PLAN[r].start;
         case (PLAN[r].kind)
            ROW_WRITE: begin
               send_item(MODE_WRITE, PLAN[r].arg[ENTRY_INDEX_W-1:0], PLAN[r].used, '0,
                         PLAN[r].typed, row_out);
            end
            ROW_SEARCH: begin
               send_item(MODE_SEARCH, '0, 1'b0, PLAN[r].arg, PLAN[r].typed, row_out);
            end
            ROW_POLICY: begin
               write_register(CSR_FIT_POLICY, PLAN[r].arg);
            end
            default: begin
               write_register(CSR_ENTRIES_IN_USE, PLAN[r].arg);
            end
         endcase
      end

      // random phases: most scan a short map, a few the whole map or beyond
      row_out = '0;
      for (phase = 0; random_sent < RANDOM_ITEMS; phase++) begin
         if (phase % 9 == 4) begin
            entries = 11'd1024;
            count = 6;
         end else if (phase % 9 == 8) begin
            entries = CSR_DATA_W'($urandom_range(1025, 2047));
            count = 6;
         end else begin
            roll = $urandom_range(0, 19);
            if (roll == 0) entries = 11'd0;
            else if (roll == 1) entries = 11'd1;
            else if (roll <= 3) entries = CSR_DATA_W'($urandom_range(65, 200));
            else entries = CSR_DATA_W'($urandom_range(2, 64));
            count = $urandom_range(15, 40);
         end
         write_register(CSR_FIT_POLICY, CSR_DATA_W'($urandom_range(0, 3)));
         write_register(CSR_ENTRIES_IN_USE, entries);
         span = (entries == 0) ? 1 : ((entries > MAP_SIZE) ? MAP_SIZE : int'(entries));
         density = $urandom_range(15, 75);
         for (k = 0; k < count; k++) begin
            mode = ($urandom_range(0, 99) < 45) ? MODE_SEARCH : MODE_WRITE;
            idx = ($urandom_range(0, 9) == 0) ?
                  ENTRY_INDEX_W'($urandom_range(0, MAP_SIZE - 1)) :
                  ENTRY_INDEX_W'($urandom_range(0, span - 1));
            used = ($urandom_range(0, 99) < density);
            roll = $urandom_range(0, 9);
            if (roll == 0) len = RUN_LENGTH_W'($urandom_range(0, 2047));
            else if (roll == 1) len = '0;
            else len = RUN_LENGTH_W'($urandom_range(1, (span / 3 < 2) ? 2 : span / 3));
            send_item(mode, idx, used, len, 1'b0, row_out);
            random_sent++;
         end
      end

      // drain and let the block settle
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("ran %0d items (%0d searches, %0d runs found) under %0d register writes",
               items_accepted, searches_sent, runs_found, settings_written);
      $display("covered all fit policies, scan lengths from zero to beyond the map");
      if (error_count == 0) begin
         $display("[bitmap_contiguous_run_allocator] OK");
      end else begin
         $display("[bitmap_contiguous_run_allocator] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
